### hdl/line_follower_steering_controller_assert.svh
// Assertion macros shared by the checker of the steering controller.
// Each macro expects clk and rst in scope; no other dependencies.
`ifndef LINE_FOLLOWER_STEERING_CONTROLLER_ASSERT_SVH
`define LINE_FOLLOWER_STEERING_CONTROLLER_ASSERT_SVH

// Same-cycle implication.
`define LFSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LFSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/lfsc_pkg.sv
// Types, constants and the line-position decode table of the steering controller.
// No dependencies.
`timescale 1ns / 1ps

package lfsc_pkg;

  localparam int NUM_SENSORS = 8;
  localparam int SAMPLE_W    = 12;
  localparam int GAIN_W      = 11;
  localparam int PAT_W       = 8;
  localparam int ERR_W       = 4;
  localparam int INT_W       = 9;
  localparam int CTL_W       = 13;
  localparam int DUTY_W      = 12;
  localparam int PROD_P_W    = GAIN_W + 1 + ERR_W;
  localparam int PROD_I_W    = GAIN_W + 1 + INT_W;
  localparam int PROD_D_W    = GAIN_W + 1 + ERR_W + 1;
  localparam int SUM_W       = PROD_I_W + 1;

  localparam int DUTY_MAX    = 4095;
  localparam int DUTY_MID    = DUTY_MAX / 2;
  localparam int OUT_LIMIT   = 4095;
  localparam int INT_LIMIT   = 255;

  localparam logic REQ_CAL = 1'b0;
  localparam logic REQ_CTL = 1'b1;

  typedef enum logic [1:0] {
    REG_KP = 2'd0,
    REG_KI = 2'd1,
    REG_KD = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic hit;
    logic signed [ERR_W-1:0] err;
  } dec_t;

  // Pipeline control handed from the top level to the merge stage.
  typedef struct packed {
    logic advance;
    logic valid;
  } pipe_ctl_t;

  // What the merge stage presents for the output register.
  typedef struct packed {
    logic valid;
    logic [PAT_W-1:0] pattern;
    logic signed [ERR_W-1:0] err;
    logic signed [CTL_W-1:0] ctl;
  } pid_res_t;

  function automatic dec_t lfsc_decode(input logic [PAT_W-1:0] pat);
    dec_t d;
    d.hit = 1'b1;
    case (pat)
      8'b1000_0000: d.err = 4'sd7;
      8'b1100_0000: d.err = 4'sd6;
      8'b0100_0000: d.err = 4'sd5;
      8'b0110_0000: d.err = 4'sd4;
      8'b0010_0000: d.err = 4'sd3;
      8'b0011_0000: d.err = 4'sd2;
      8'b0001_0000: d.err = 4'sd1;
      8'b0001_1000: d.err = 4'sd0;
      8'b0000_1000: d.err = -4'sd1;
      8'b0000_1100: d.err = -4'sd2;
      8'b0000_0100: d.err = -4'sd3;
      8'b0000_0110: d.err = -4'sd4;
      8'b0000_0010: d.err = -4'sd5;
      8'b0000_0011: d.err = -4'sd6;
      8'b0000_0001: d.err = -4'sd7;
      default: begin
        d.hit = 1'b0;
        d.err = 4'sd0;
      end
    endcase
    return d;
  endfunction

endpackage

### hdl/lfsc_lane.sv
// One sensor lane: running min/max calibration, threshold, and the line compare.
// Depends on lfsc_pkg.
`timescale 1ns / 1ps

module lfsc_lane
  import lfsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cal_en,
  input  logic [SAMPLE_W-1:0] sample,
  output logic                hit
);

  logic [SAMPLE_W-1:0] sensor_min;
  logic [SAMPLE_W-1:0] sensor_max;
  logic [SAMPLE_W-1:0] sensor_threshold;
  logic [SAMPLE_W-1:0] min_next;
  logic [SAMPLE_W-1:0] max_next;
  logic [SAMPLE_W:0]   span_sum;
  logic [15:0]         sample_x10;
  logic [15:0]         thr_x11;

  assign min_next = (sample < sensor_min) ? sample : sensor_min;
  assign max_next = (sample > sensor_max) ? sample : sensor_max;
  assign span_sum = {1'b0, min_next} + {1'b0, max_next};

  // 10*s > 11*t is the 1.1 ratio without a fraction.
  assign sample_x10 = 16'(sample) * 16'd10;
  assign thr_x11    = 16'(sensor_threshold) * 16'd11;
  assign hit        = sample_x10 > thr_x11;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_min       <= '1;
      sensor_max       <= '0;
      sensor_threshold <= '0;
    end else if (cal_en) begin
      sensor_min       <= min_next;
      sensor_max       <= max_next;
      sensor_threshold <= span_sum[SAMPLE_W:1];
    end
  end

endmodule

### hdl/lfsc_pid.sv
// Merge stage: decodes the lane pattern, keeps error and integral state,
// forms the three gain products and the clamped controller output. Depends on lfsc_pkg.
`timescale 1ns / 1ps

module lfsc_pid
  import lfsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  pipe_ctl_t         ctl,
  input  logic [PAT_W-1:0]  pattern,
  input  logic [GAIN_W-1:0] kp,
  input  logic [GAIN_W-1:0] ki,
  input  logic [GAIN_W-1:0] kd,
  output pid_res_t          res
);

  logic signed [ERR_W-1:0]    held_error;
  logic signed [INT_W-1:0]    integral_sum;

  dec_t                       dec;
  logic signed [ERR_W-1:0]    err;
  logic signed [INT_W:0]      int_raw;
  logic signed [INT_W-1:0]    integ;
  logic signed [ERR_W:0]      deriv;
  logic signed [GAIN_W:0]     gp;
  logic signed [GAIN_W:0]     gi;
  logic signed [GAIN_W:0]     gd;
  logic signed [PROD_P_W-1:0] prod_p_next;
  logic signed [PROD_I_W-1:0] prod_i_next;
  logic signed [PROD_D_W-1:0] prod_d_next;

  logic                       v2;
  logic [PAT_W-1:0]           pattern2;
  logic signed [ERR_W-1:0]    err2;
  logic signed [PROD_P_W-1:0] prod_p;
  logic signed [PROD_I_W-1:0] prod_i;
  logic signed [PROD_D_W-1:0] prod_d;
  logic signed [SUM_W-1:0]    total;

  always_comb begin
    dec = lfsc_decode(pattern);
    err = dec.hit ? dec.err : held_error;
    int_raw = {integral_sum[INT_W-1], integral_sum} + (INT_W+1)'(err);
    if (err == '0) begin
      integ = '0;
    end else if (int_raw > (INT_W+1)'(INT_LIMIT)) begin
      integ = INT_W'(INT_LIMIT);
    end else if (int_raw < -(INT_W+1)'(INT_LIMIT)) begin
      integ = -INT_W'(INT_LIMIT);
    end else begin
      integ = int_raw[INT_W-1:0];
    end
    deriv = {err[ERR_W-1], err} - {held_error[ERR_W-1], held_error};
  end

  assign gp = {1'b0, kp};
  assign gi = {1'b0, ki};
  assign gd = {1'b0, kd};
  assign prod_p_next = gp * err;
  assign prod_i_next = gi * integ;
  assign prod_d_next = gd * deriv;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_error   <= '0;
      integral_sum <= '0;
      v2           <= 1'b0;
    end else if (ctl.advance) begin
      v2 <= ctl.valid;
      if (ctl.valid) begin
        held_error   <= err;
        integral_sum <= integ;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance && ctl.valid) begin
      pattern2 <= pattern;
      err2     <= err;
      prod_p   <= prod_p_next;
      prod_i   <= prod_i_next;
      prod_d   <= prod_d_next;
    end
  end

  assign total = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);

  always_comb begin
    res.valid   = v2;
    res.pattern = pattern2;
    res.err     = err2;
    if (total > SUM_W'(OUT_LIMIT)) begin
      res.ctl = CTL_W'(OUT_LIMIT);
    end else if (total < -SUM_W'(OUT_LIMIT)) begin
      res.ctl = -CTL_W'(OUT_LIMIT);
    end else begin
      res.ctl = total[CTL_W-1:0];
    end
  end

endmodule

### hdl/line_follower_steering_controller.sv
// Top level of the line-follower steering controller: handshakes, gain registers,
// eight sensor lanes, the merge stage and the output register. Depends on lfsc_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall): one transaction carries req_type and eight
//   samples. req_type 0 calibrates the lanes and gives no result; req_type 1 is a
//   control set and gives exactly one result on the output channel.
//   Output channel (out_valid / out_stall): pattern, line error, controller output
//   and the two motor duties.
//   Configuration (cfg_valid / cfg_ready): index 0 kp, 1 ki, 2 kd; other indexes
//   are dropped. cfg_ready is always high; write gains only while the block is idle.
// Timing
//   One transaction per cycle while no result is stalled at the output. A result
//   is formed from its control set by the lane compare at the input, then decode
//   and gain products, then the sum, clamp and duty register.
//   A calibration set takes effect for a control set in the very next cycle.
// Reset and stall
//   rst (synchronous) clears gains, calibration (min 4095, max 0, threshold 0),
//   held error, integral and all valid flags. While a result on the output is
//   stalled the whole pipeline holds and in_stall is raised.

module line_follower_steering_controller
  import lfsc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,

  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     req_type,
  input  logic [SAMPLE_W-1:0]      sample_0,
  input  logic [SAMPLE_W-1:0]      sample_1,
  input  logic [SAMPLE_W-1:0]      sample_2,
  input  logic [SAMPLE_W-1:0]      sample_3,
  input  logic [SAMPLE_W-1:0]      sample_4,
  input  logic [SAMPLE_W-1:0]      sample_5,
  input  logic [SAMPLE_W-1:0]      sample_6,
  input  logic [SAMPLE_W-1:0]      sample_7,

  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [PAT_W-1:0]         sensor_pattern,
  output logic signed [ERR_W-1:0]  line_error,
  output logic signed [CTL_W-1:0]  control_out,
  output logic [DUTY_W-1:0]        left_duty,
  output logic [DUTY_W-1:0]        right_duty,

  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [GAIN_W-1:0]        cfg_data
);

  localparam int DSUM_W = DUTY_W + 2;

  logic [GAIN_W-1:0]        kp;
  logic [GAIN_W-1:0]        ki;
  logic [GAIN_W-1:0]        kd;

  logic                     advance;
  logic                     in_accept;
  logic                     cal_en;
  logic [SAMPLE_W-1:0]      smp [NUM_SENSORS];
  logic [PAT_W-1:0]         lane_hit;

  logic                     v1;
  logic [PAT_W-1:0]         pattern1;
  pipe_ctl_t                pid_ctl;
  pid_res_t                 res;

  logic signed [DSUM_W-1:0] left_sum;
  logic signed [DSUM_W-1:0] right_sum;
  logic [DUTY_W-1:0]        left_next;
  logic [DUTY_W-1:0]        right_next;

  // Everything moves together unless the output holds an untaken result.
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = !advance;
  assign in_accept = in_valid && advance;
  assign cal_en    = in_accept && (req_type == REQ_CAL);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp <= '0;
      ki <= '0;
      kd <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_KP:  kp <= cfg_data;
        REG_KI:  ki <= cfg_data;
        REG_KD:  kd <= cfg_data;
        default: ;
      endcase
    end
  end

  assign smp[0] = sample_0;
  assign smp[1] = sample_1;
  assign smp[2] = sample_2;
  assign smp[3] = sample_3;
  assign smp[4] = sample_4;
  assign smp[5] = sample_5;
  assign smp[6] = sample_6;
  assign smp[7] = sample_7;

  for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
    lfsc_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .cal_en (cal_en),
      .sample (smp[g]),
      .hit    (lane_hit[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= in_accept && (req_type == REQ_CTL);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pattern1 <= lane_hit;
    end
  end

  assign pid_ctl.advance = advance;
  assign pid_ctl.valid   = v1;

  lfsc_pid u_pid (
    .clk     (clk),
    .rst     (rst),
    .ctl     (pid_ctl),
    .pattern (pattern1),
    .kp      (kp),
    .ki      (ki),
    .kd      (kd),
    .res     (res)
  );

  assign left_sum  = DSUM_W'(DUTY_MID) + DSUM_W'(res.ctl);
  assign right_sum = DSUM_W'(DUTY_MID) - DSUM_W'(res.ctl);

  always_comb begin
    if (left_sum < 0) begin
      left_next = '0;
    end else if (left_sum > DSUM_W'(DUTY_MAX)) begin
      left_next = DUTY_W'(DUTY_MAX);
    end else begin
      left_next = left_sum[DUTY_W-1:0];
    end
    if (right_sum < 0) begin
      right_next = '0;
    end else if (right_sum > DSUM_W'(DUTY_MAX)) begin
      right_next = DUTY_W'(DUTY_MAX);
    end else begin
      right_next = right_sum[DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      sensor_pattern <= res.pattern;
      line_error     <= res.err;
      control_out    <= res.ctl;
      left_duty      <= left_next;
      right_duty     <= right_next;
    end
  end

endmodule

### hdl/lfsc_checker.sv
// Port-level checker for the steering controller, bound to the top level.
// Depends on lfsc_pkg and line_follower_steering_controller_assert.svh.
`timescale 1ns / 1ps

`include "line_follower_steering_controller_assert.svh"

module lfsc_checker
  import lfsc_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [PAT_W-1:0]        sensor_pattern,
  input logic signed [ERR_W-1:0] line_error,
  input logic signed [CTL_W-1:0] control_out,
  input logic [DUTY_W-1:0]       left_duty,
  input logic [DUTY_W-1:0]       right_duty
);

  logic                          in_range;
  logic                          centered;
  logic                          zero_ctl;
  logic                          mid_duty;
  logic                          out_held;
  logic [CTL_W+2*DUTY_W-1:0]     out_word;

  assign in_range = (control_out != 13'h1000) && (line_error != 4'h8);
  assign centered = out_valid && (sensor_pattern == 8'h18);
  assign zero_ctl = out_valid && (control_out == 13'sd0);
  assign mid_duty = (left_duty == DUTY_W'(DUTY_MID)) && (right_duty == DUTY_W'(DUTY_MID));
  assign out_held = out_valid && out_stall;
  assign out_word = {control_out, left_duty, right_duty};

  `LFSC_ASSERT_NOW(a_out_range, out_valid, in_range, "output field out of range")

  `LFSC_ASSERT_NOW(a_center_decode, centered, line_error == 4'sd0, "center pattern not zero error")

  `LFSC_ASSERT_NOW(a_zero_drive, zero_ctl, mid_duty, "zero output without mid duties")

  `LFSC_ASSERT_NEXT(a_stall_hold, out_held, out_valid && $stable(out_word), "stalled result changed")

endmodule

bind line_follower_steering_controller lfsc_checker u_lfsc_checker (.*);

### verif/tb_line_follower_steering_controller.sv
// Self-checking testbench for the line-follower steering controller.
// Holds its own model of calibration, line decode and PID drive; depends on lfsc_pkg
// and line_follower_steering_controller.
`timescale 1ns / 1ps

module tb_line_follower_steering_controller;
  import lfsc_pkg::*;

  typedef logic [NUM_SENSORS-1:0][SAMPLE_W-1:0] sample_set_t;

  typedef struct packed {
    logic [PAT_W-1:0]        pattern;
    logic signed [ERR_W-1:0] err;
    logic signed [CTL_W-1:0] ctl;
    logic [DUTY_W-1:0]       left_d;
    logic [DUTY_W-1:0]       right_d;
  } steer_t;

  localparam logic [1:0] REG_STRAY = 2'd3;  // past kd, must be dropped
  localparam int NO_HIT = 99;
  localparam int LAST_POS = 14;

  // Line position k (0..14) maps to error k-7; the entry at LAST_POS is error +7.
  localparam logic [LAST_POS:0][PAT_W-1:0] LINE_PATTERNS = {
    8'h80, 8'hC0, 8'h40, 8'h60, 8'h20, 8'h30, 8'h10, 8'h18,
    8'h08, 8'h0C, 8'h04, 8'h06, 8'h02, 8'h03, 8'h01
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = REQ_CAL;
  logic [SAMPLE_W-1:0] sample_0 = '0, sample_1 = '0, sample_2 = '0, sample_3 = '0;
  logic [SAMPLE_W-1:0] sample_4 = '0, sample_5 = '0, sample_6 = '0, sample_7 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PAT_W-1:0] sensor_pattern;
  logic signed [ERR_W-1:0] line_error;
  logic signed [CTL_W-1:0] control_out;
  logic [DUTY_W-1:0] left_duty;
  logic [DUTY_W-1:0] right_duty;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_KP;
  logic [GAIN_W-1:0] cfg_data = '0;

  line_follower_steering_controller dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .sample_0(sample_0), .sample_1(sample_1), .sample_2(sample_2), .sample_3(sample_3),
    .sample_4(sample_4), .sample_5(sample_5), .sample_6(sample_6), .sample_7(sample_7),
    .out_valid(out_valid), .out_stall(out_stall), .sensor_pattern(sensor_pattern),
    .line_error(line_error), .control_out(control_out),
    .left_duty(left_duty), .right_duty(right_duty),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Model state: calibration, PID history and gains.
  logic [SAMPLE_W-1:0] cal_min [NUM_SENSORS];
  logic [SAMPLE_W-1:0] cal_max [NUM_SENSORS];
  logic [SAMPLE_W-1:0] cal_thr [NUM_SENSORS];
  logic signed [ERR_W-1:0] last_err = '0;
  logic signed [INT_W-1:0] integ_acc = '0;
  logic [GAIN_W-1:0] gain_kp = '0, gain_ki = '0, gain_kd = '0;

  steer_t pending_steer[$];

  int send_pct = 0;
  int stall_pct = 0;
  int hold_req_len = 0;
  int hold_left = 0;
  int line_pos = 7;
  int run_left = 0;
  int mismatch_count = 0;
  int n_cal = 0, n_ctl = 0, n_checked = 0, n_writes = 0;

  initial begin
    for (int i = 0; i < NUM_SENSORS; i++) begin
      cal_min[i] = '1;
      cal_max[i] = '0;
      cal_thr[i] = '0;
    end
  end

  function automatic int clip(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int decode_line(input logic [PAT_W-1:0] pat, input int fallback);
    for (int k = 0; k <= LAST_POS; k++)
      if (LINE_PATTERNS[k] == pat) return k - 7;
    return fallback;
  endfunction

  // Pick samples that land on the wanted pattern under the current thresholds.
  function automatic sample_set_t samples_for(input logic [PAT_W-1:0] pat);
    sample_set_t smp;
    int lim;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      lim = (11 * int'(cal_thr[i])) / 10;
      if (pat[i]) begin
        smp[i] = (lim >= 4095) ? 12'hFFF : SAMPLE_W'($urandom_range(4095, lim + 1));
      end else begin
        smp[i] = SAMPLE_W'($urandom_range(clip(lim, 0, 4095), 0));
      end
    end
    return smp;
  endfunction

  function automatic sample_set_t random_samples();
    sample_set_t smp;
    for (int i = 0; i < NUM_SENSORS; i++) smp[i] = SAMPLE_W'($urandom_range(4095, 0));
    return smp;
  endfunction

  task automatic predict_steering(input logic rt, input sample_set_t smp);
    steer_t want;
    logic [PAT_W-1:0] pat;
    int e, acc, dlt, ctl;
    if (rt == REQ_CAL) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        if (smp[i] > cal_max[i]) cal_max[i] = smp[i];
        if (smp[i] < cal_min[i]) cal_min[i] = smp[i];
        cal_thr[i] = SAMPLE_W'((int'(cal_min[i]) + int'(cal_max[i])) / 2);
      end
      n_cal++;
      return;
    end
    pat = '0;
    for (int i = 0; i < NUM_SENSORS; i++)
      if (10 * int'(smp[i]) > 11 * int'(cal_thr[i])) pat[i] = 1'b1;
    // Unknown pattern: hold the last error, so the derivative term is zero.
    e = decode_line(pat, int'(last_err));
    acc = (e == 0) ? 0 : clip(int'(integ_acc) + e, -INT_LIMIT, INT_LIMIT);
    dlt = e - int'(last_err);
    ctl = clip(int'(gain_kp) * e + int'(gain_ki) * acc + int'(gain_kd) * dlt,
               -OUT_LIMIT, OUT_LIMIT);
    integ_acc = INT_W'(acc);
    last_err = ERR_W'(e);
    want.pattern = pat;
    want.err = ERR_W'(e);
    want.ctl = CTL_W'(ctl);
    want.left_d = DUTY_W'(clip(DUTY_MID + ctl, 0, DUTY_MAX));
    want.right_d = DUTY_W'(clip(DUTY_MID - ctl, 0, DUTY_MAX));
    pending_steer.push_back(want);
    n_ctl++;
  endtask

  // Valid stays high after a transaction so back-to-back sets need no extra edge.
  task automatic send_item(input logic rt, input sample_set_t smp);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    sample_0 <= smp[0];
    sample_1 <= smp[1];
    sample_2 <= smp[2];
    sample_3 <= smp[3];
    sample_4 <= smp[4];
    sample_5 <= smp[5];
    sample_6 <= smp[6];
    sample_7 <= smp[7];
    do @(posedge clk); while (in_stall);
    predict_steering(rt, smp);
  endtask

  // Drop valid, wait out every pending result, then let calibration sets drain.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_steer.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= GAIN_W'(val);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_KP: gain_kp = GAIN_W'(val);
      REG_KI: gain_ki = GAIN_W'(val);
      REG_KD: gain_kd = GAIN_W'(val);
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic set_gains(input int g_p, input int g_i, input int g_d, input bit stray);
    settle();
    write_reg(REG_KP, g_p);
    write_reg(REG_KI, g_i);
    write_reg(REG_KD, g_d);
    if (stray) write_reg(REG_STRAY, $urandom_range(2047));
    cfg_valid <= 1'b0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] got,
                             input logic signed [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // Receiver: random stall, or a counted hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req_len > 0) begin
      hold_left = hold_req_len;
      hold_req_len = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    steer_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_steer.size() == 0) begin
        report_mismatch($sformatf("result with pattern %b and nothing expected",
                                  sensor_pattern));
      end else begin
        want = pending_steer.pop_front();
        check_field("sensor_pattern", sensor_pattern, want.pattern);
        check_field("line_error", line_error, want.err);
        check_field("control_out", control_out, want.ctl);
        check_field("left_duty", left_duty, want.left_d);
        check_field("right_duty", right_duty, want.right_d);
        n_checked++;
      end
    end
  end

  // Control sets before any calibration: every nonzero sample sets its bit.
  task automatic test_uncalibrated();
    sample_set_t smp;
    set_gains(2047, 2047, 2047, 1'b1);
    smp = '0;
    send_item(REQ_CTL, smp);
    smp[3] = 12'd1;
    send_item(REQ_CTL, smp);
    smp = '1;
    send_item(REQ_CTL, smp);
  endtask

  // Calibrate, sweep the whole decode table, then an unknown pattern and the
  // exact threshold boundary.
  task automatic test_decode_table();
    sample_set_t smp;
    int lim;
    smp = '0;
    send_item(REQ_CAL, smp);
    for (int i = 0; i < NUM_SENSORS; i++) smp[i] = SAMPLE_W'(400 + 300 * i);
    send_item(REQ_CAL, smp);
    for (int k = 0; k <= LAST_POS; k++) send_item(REQ_CTL, samples_for(LINE_PATTERNS[k]));
    send_item(REQ_CTL, samples_for(8'h5A));
    for (int i = 0; i < NUM_SENSORS; i++) begin
      lim = (11 * int'(cal_thr[i])) / 10;
      smp[i] = SAMPLE_W'(lim + (i % 2));
    end
    send_item(REQ_CTL, smp);
  endtask

  // Hold the output off long enough to fill the pipeline and stall the input.
  task automatic test_backpressure();
    send_pct = 0;
    stall_pct = 0;
    set_gains($urandom_range(300), $urandom_range(20), $urandom_range(300), 1'b0);
    hold_req_len = 80;
    for (int n = 0; n < 40; n++)
      send_item(REQ_CTL, samples_for(LINE_PATTERNS[n % (LAST_POS + 1)]));
    settle();
  endtask

  // Mostly a line that drifts or sits at one position, plus calibration, noise and
  // patterns outside the table.
  task automatic run_traffic(input int count, input int cal_top);
    sample_set_t smp;
    logic [PAT_W-1:0] pat;
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        for (int i = 0; i < NUM_SENSORS; i++) smp[i] = SAMPLE_W'($urandom_range(cal_top, 0));
        send_item(REQ_CAL, smp);
      end else if (r < 16) begin
        send_item(REQ_CTL, random_samples());
      end else if (r < 22) begin
        do pat = PAT_W'($urandom); while (decode_line(pat, NO_HIT) != NO_HIT);
        send_item(REQ_CTL, samples_for(pat));
      end else begin
        if (run_left > 0) begin
          run_left--;
        end else if ($urandom_range(99) < 5) begin
          line_pos = $urandom_range(LAST_POS);
          run_left = $urandom_range(60, 10);
        end else begin
          line_pos = clip(line_pos + int'($urandom_range(2)) - 1, 0, LAST_POS);
        end
        send_item(REQ_CTL, samples_for(LINE_PATTERNS[line_pos]));
      end
    end
  endtask

  task automatic test_random_tracking();
    int cal_top;
    cal_top = 1500;
    for (int m = 0; m < 3; m++) begin
      case (m)
        0: begin
          send_pct = 38;
          stall_pct = 61;
        end
        1: begin
          send_pct = 61;
          stall_pct = 38;
        end
        default: begin
          send_pct = 0;
          stall_pct = 0;
        end
      endcase
      for (int ph = 0; ph < 4; ph++) begin
        case (ph)
          0: set_gains($urandom_range(400), $urandom_range(16), $urandom_range(400), 1'b0);
          1: set_gains($urandom_range(2047), $urandom_range(2047), $urandom_range(2047), 1'b1);
          2: begin
            if (m == 1) set_gains(0, 0, 0, 1'b0);
            else set_gains(2047, 2047, 2047, 1'b0);
          end
          default: set_gains($urandom_range(600), $urandom_range(40), 0, 1'b0);
        endcase
        run_traffic(105, cal_top);
        cal_top = clip(cal_top + 300, 0, 4095);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_uncalibrated();
    test_decode_table();
    test_backpressure();
    test_random_tracking();
    settle();
    repeat (10) @(posedge clk);
    $display("Covered %0d calibration and %0d control sets, %0d results compared,",
             n_cal, n_ctl, n_checked);
    $display("%0d gain writes, decode table sweep, output hold-off and three idle mixes",
             n_writes);
    if (mismatch_count == 0 && pending_steer.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("timeout with %0d results outstanding", pending_steer.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
